### design/source_text_tokenizer_macros.svh
// Assertion macros used by the tokenizer checker
`ifndef SOURCE_TEXT_TOKENIZER_MACROS_SVH
`define SOURCE_TEXT_TOKENIZER_MACROS_SVH

// Combinational implication, sampled on the rising clock edge, off during reset
`define STT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset
`define STT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/stt_pkg.sv
// Types and constants shared by the source text tokenizer
package stt_pkg;

  // Width of the position and run state
  localparam int unsigned OFFSET_BITS = 32;
  localparam int unsigned LINE_BITS   = 16;
  localparam int unsigned COLUMN_BITS = 16;
  localparam int unsigned LENGTH_BITS = 16;

  // Widths of the result word fields
  localparam int unsigned LINE_W   = 16;
  localparam int unsigned COLUMN_W = 16;
  localparam int unsigned OFFSET_W = 32;
  localparam int unsigned LENGTH_W = 16;
  localparam int unsigned VALUE_W  = 64;

  // Output queue depth; an input word may push two tokens at once
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W      = $clog2(FIFO_DEPTH + 1);

  // Character codes
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_ZERO  = 8'h30;

  // The one keyword, "func"
  localparam logic [3:0][7:0] KW_TEXT = {8'h63, 8'h6E, 8'h75, 8'h66};
  localparam logic [2:0] KW_DONE     = 3'd4;
  localparam logic [2:0] KW_MISMATCH = 3'd7;

  typedef enum logic [3:0] {
    TK_EQUALS    = 4'd0,
    TK_SEMICOLON = 4'd1,
    TK_PLUS      = 4'd2,
    TK_MINUS     = 4'd3,
    TK_ASTERISK  = 4'd4,
    TK_SLASH     = 4'd5,
    TK_IDENT     = 4'd6,
    TK_KEYWORD   = 4'd7,
    TK_INTEGER   = 4'd8,
    TK_FLOAT     = 4'd9,
    TK_ERROR     = 4'd10
  } tok_kind_e;

  typedef enum logic [1:0] {
    RUN_NONE   = 2'd0,
    RUN_IDENT  = 2'd1,
    RUN_NUMBER = 2'd2
  } run_kind_e;

  // One token as it leaves the block
  typedef struct packed {
    tok_kind_e           kind;
    logic [LINE_W-1:0]   line;
    logic [COLUMN_W-1:0] column;
    logic [OFFSET_W-1:0] offset;
    logic [LENGTH_W-1:0] length;
    logic [VALUE_W-1:0]  value;
    logic [7:0]          bad;
    logic                last;
  } tok_t;

  // Push from the scanner into the output queue: first and second token
  typedef struct packed {
    logic [1:0] num;
    tok_t       tok0;
    tok_t       tok1;
  } push_t;

endpackage

### design/stt_if.sv
// Valid/ready channel interfaces for source bytes and tokens
interface stt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       end_of_text;

  modport source (output valid, output character, output end_of_text, input ready);
  modport sink   (input valid, input character, input end_of_text, output ready);
endinterface

interface stt_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  token_kind;
  logic [15:0] line;
  logic [15:0] column;
  logic [31:0] offset;
  logic [15:0] length;
  logic [63:0] integer_value;
  logic [7:0]  bad_char;
  logic        last_of_item;

  modport source (output valid, output token_kind, output line, output column,
                  output offset, output length, output integer_value,
                  output bad_char, output last_of_item, input ready);
  modport sink   (input valid, input token_kind, input line, input column,
                  input offset, input length, input integer_value,
                  input bad_char, input last_of_item, output ready);
endinterface

### design/stt_fifo.sv
// Output token queue: takes up to two tokens a cycle, hands out one
module stt_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  stt_pkg::push_t push_i,
  output logic          room_o,
  stt_out_if.source     out_o
);
  import stt_pkg::*;

  tok_t             mem [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             pop;
  tok_t             head;

  assign pop    = out_o.valid && out_o.ready;
  assign room_o = cnt_q <= CNT_W'(FIFO_DEPTH - 2);

  // Pointer and fill count update
  always_comb begin
    wr_d  = wr_q + PTR_W'(push_i.num);
    rd_d  = rd_q + PTR_W'(pop);
    cnt_d = cnt_q + CNT_W'(push_i.num) - CNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Token storage
  always_ff @(posedge clk_i) begin
    if (push_i.num != 2'd0) begin
      mem[wr_q] <= push_i.tok0;
    end
    if (push_i.num == 2'd2) begin
      mem[wr_q + PTR_W'(1)] <= push_i.tok1;
    end
  end

  assign head = mem[rd_q];

  assign out_o.valid         = cnt_q != '0;
  assign out_o.token_kind    = head.kind;
  assign out_o.line          = head.line;
  assign out_o.column        = head.column;
  assign out_o.offset        = head.offset;
  assign out_o.length        = head.length;
  assign out_o.integer_value = head.value;
  assign out_o.bad_char      = head.bad;
  assign out_o.last_of_item  = head.last;

endmodule

### design/stt_core.sv
// Scanner: input register, byte classification, run state and token build
module stt_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  stt_in_if.sink         in_i,
  input  logic           room_i,
  output stt_pkg::push_t push_o
);
  import stt_pkg::*;

  typedef struct packed {
    logic [OFFSET_BITS-1:0] pos_offset;
    logic [LINE_BITS-1:0]   pos_line;
    logic [COLUMN_BITS-1:0] pos_column;
    run_kind_e              run_kind;
    logic [LINE_BITS-1:0]   run_line;
    logic [COLUMN_BITS-1:0] run_column;
    logic [OFFSET_BITS-1:0] run_offset;
    logic [LENGTH_BITS-1:0] run_length;
    logic                   run_dot;
    logic [VALUE_W-1:0]     run_value;
    logic [2:0]             kw_prog;
    logic                   failed;
  } state_t;

  state_t st_q, st_d;

  logic       inq_valid_q;
  logic [7:0] inq_char_q;
  logic       inq_eot_q;
  logic       step;

  logic [7:0] c;
  logic       is_letter, is_digit, is_ws, is_punct;
  logic       ext_ident, ext_number;
  logic [3:0] digit;
  logic [VALUE_W+3:0] acc;
  tok_kind_e  punct_kind;
  tok_t       run_tok, chr_tok;
  logic       run_v, chr_v;

  // Input register: refills in the same cycle it drains
  assign step       = inq_valid_q && room_i;
  assign in_i.ready = !inq_valid_q || room_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inq_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      inq_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      inq_char_q <= in_i.character;
      inq_eot_q  <= in_i.end_of_text;
    end
  end

  // Byte classes
  assign c         = inq_char_q;
  assign is_letter = c inside {[8'h61:8'h7A], [8'h41:8'h5A]};
  assign is_digit  = c inside {[8'h30:8'h39]};
  assign is_ws     = c inside {CH_SPACE, CH_TAB, CH_CR};
  assign is_punct  = c inside {CH_EQ, CH_SEMI, CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH};
  assign digit     = c[3:0] - CH_ZERO[3:0];

  assign ext_ident  = (st_q.run_kind == RUN_IDENT) && (is_letter || is_digit || c == CH_UNDER);
  assign ext_number = (st_q.run_kind == RUN_NUMBER) && (is_digit || c == CH_DOT);

  // value * 10 + digit, with carry bits to spot saturation
  assign acc = ({4'd0, st_q.run_value} << 3) + ({4'd0, st_q.run_value} << 1)
             + (VALUE_W + 4)'(digit);

  always_comb begin
    case (c)
      CH_EQ:    punct_kind = TK_EQUALS;
      CH_SEMI:  punct_kind = TK_SEMICOLON;
      CH_PLUS:  punct_kind = TK_PLUS;
      CH_MINUS: punct_kind = TK_MINUS;
      CH_STAR:  punct_kind = TK_ASTERISK;
      default:  punct_kind = TK_SLASH;
    endcase
  end

  // Token of the open run
  always_comb begin
    run_tok        = '0;
    run_tok.line   = LINE_W'(st_q.run_line);
    run_tok.column = COLUMN_W'(st_q.run_column);
    run_tok.offset = OFFSET_W'(st_q.run_offset);
    run_tok.length = LENGTH_W'(st_q.run_length);
    if (st_q.run_kind == RUN_IDENT) begin
      run_tok.kind = (st_q.kw_prog == KW_DONE) ? TK_KEYWORD : TK_IDENT;
    end else if (st_q.run_dot) begin
      run_tok.kind = TK_FLOAT;
    end else begin
      run_tok.kind  = TK_INTEGER;
      run_tok.value = st_q.run_value;
    end
  end

  // Next state and the token of the current byte
  always_comb begin
    st_d           = st_q;
    run_v          = 1'b0;
    chr_v          = 1'b0;
    chr_tok        = '0;
    chr_tok.line   = LINE_W'(st_q.pos_line);
    chr_tok.column = COLUMN_W'(st_q.pos_column);
    chr_tok.offset = OFFSET_W'(st_q.pos_offset);
    chr_tok.length = LENGTH_W'(LENGTH_BITS'(1));
    chr_tok.kind   = punct_kind;

    if (inq_eot_q) begin
      run_v = !st_q.failed && (st_q.run_kind != RUN_NONE);
      st_d  = '0;
    end else if (!st_q.failed) begin
      if (ext_ident || ext_number) begin
        if (st_q.run_length != '1) begin
          st_d.run_length = st_q.run_length + LENGTH_BITS'(1);
        end
        if (ext_ident) begin
          if (st_q.kw_prog < KW_DONE && c == KW_TEXT[st_q.kw_prog[1:0]]) begin
            st_d.kw_prog = st_q.kw_prog + 3'd1;
          end else begin
            st_d.kw_prog = KW_MISMATCH;
          end
        end else if (c == CH_DOT) begin
          st_d.run_dot = 1'b1;
        end else begin
          st_d.run_value = (acc[VALUE_W+3:VALUE_W] != '0) ? '1 : acc[VALUE_W-1:0];
        end
        st_d.pos_offset = st_q.pos_offset + OFFSET_BITS'(1);
        st_d.pos_column = st_q.pos_column + COLUMN_BITS'(1);
      end else begin
        // Any open run ends here, then the byte is taken on its own
        run_v         = st_q.run_kind != RUN_NONE;
        st_d.run_kind = RUN_NONE;
        if (is_ws) begin
          st_d.pos_offset = st_q.pos_offset + OFFSET_BITS'(1);
          st_d.pos_column = st_q.pos_column + COLUMN_BITS'(1);
        end else if (c == CH_NL) begin
          st_d.pos_offset = st_q.pos_offset + OFFSET_BITS'(1);
          st_d.pos_line   = st_q.pos_line + LINE_BITS'(1);
          st_d.pos_column = '0;
        end else if (is_punct) begin
          chr_v           = 1'b1;
          st_d.pos_offset = st_q.pos_offset + OFFSET_BITS'(1);
          st_d.pos_column = st_q.pos_column + COLUMN_BITS'(1);
        end else if (is_letter || is_digit) begin
          st_d.run_kind   = is_letter ? RUN_IDENT : RUN_NUMBER;
          st_d.run_line   = st_q.pos_line;
          st_d.run_column = st_q.pos_column;
          st_d.run_offset = st_q.pos_offset;
          st_d.run_length = LENGTH_BITS'(1);
          st_d.run_dot    = 1'b0;
          st_d.run_value  = is_digit ? VALUE_W'(digit) : '0;
          st_d.kw_prog    = (is_letter && c == KW_TEXT[0]) ? 3'd1 : KW_MISMATCH;
          st_d.pos_offset = st_q.pos_offset + OFFSET_BITS'(1);
          st_d.pos_column = st_q.pos_column + COLUMN_BITS'(1);
        end else begin
          // Bad byte: error token, then deaf until end of text
          chr_v        = 1'b1;
          chr_tok.kind = TK_ERROR;
          chr_tok.bad  = c;
          st_d.failed  = 1'b1;
        end
      end
    end
  end

  // Pack tokens in order, flag the last one
  always_comb begin
    push_o      = '0;
    push_o.tok0 = run_v ? run_tok : chr_tok;
    push_o.tok1 = chr_tok;
    if (step) begin
      push_o.num = {1'b0, run_v} + {1'b0, chr_v};
    end
    if (run_v && chr_v) begin
      push_o.tok1.last = 1'b1;
    end else begin
      push_o.tok0.last = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (step) begin
      st_q <= st_d;
    end
  end

endmodule

### design/source_text_tokenizer.sv
// Source text tokenizer: top level
//
// in_i carries one source byte per word (character), or an end-of-text
// marker (end_of_text = 1) that flushes any open identifier or number
// and returns position and run state to zero. out_o carries tokens with
// kind, start line, column and byte offset, length, integer value and the
// offending byte of an error token; last_of_item marks the final token
// caused by one input word. A word may cause zero, one or two tokens.
// Both channels move a word when valid and ready are high at a clock edge.
// A token shows on out_o once its byte has passed the input register and
// the scanner has pushed it into the output queue.
// Throughput: one byte per cycle while the output queue has room; a byte
// that closes a run and is itself a token pushes two entries; out_o drains
// one per cycle. A four-entry output queue keeps the input side moving
// while out_o stalls; in_i.ready drops while a byte waits in the input
// register and fewer than two queue entries are free.
// Reset (rst_ni low, asynchronous) empties the queue and clears position,
// run and error state.
module source_text_tokenizer (
  input  logic      clk_i,
  input  logic      rst_ni,
  stt_in_if.sink    in_i,
  stt_out_if.source out_o
);
  import stt_pkg::*;

  push_t push;
  logic  room;

  stt_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .room_i (room),
    .push_o (push)
  );

  stt_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .room_o (room),
    .out_o  (out_o)
  );

endmodule

### design/stt_checker.sv
// Port-level checks on the tokenizer output, bound to the top level
`include "source_text_tokenizer_macros.svh"

module stt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [3:0]  token_kind_i,
  input logic [15:0] length_i,
  input logic [63:0] integer_value_i,
  input logic [7:0]  bad_char_i,
  input logic        last_of_item_i
);
  import stt_pkg::*;

  logic is_single;
  assign is_single = token_kind_i <= TK_SLASH;

  // A stalled word stays put
  `STT_ASSERT_NXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(token_kind_i) && $stable(integer_value_i), "token changed while stalled")
  // Operators are one byte long
  `STT_ASSERT_IMP(a_single_len, out_valid_i && is_single, length_i == 16'd1, "operator token length not one")
  // Only integers carry a value
  `STT_ASSERT_IMP(a_value_zero, out_valid_i && token_kind_i != TK_INTEGER, integer_value_i == 64'd0, "value on non-integer token")
  // Error token is one byte and ends its item; other kinds carry no bad byte
  `STT_ASSERT_IMP(a_error_shape, out_valid_i && token_kind_i == TK_ERROR, length_i == 16'd1 && last_of_item_i, "malformed error token")
  `STT_ASSERT_IMP(a_bad_zero, out_valid_i && token_kind_i != TK_ERROR, bad_char_i == 8'd0, "bad byte on non-error token")

endmodule

bind source_text_tokenizer stt_checker u_stt_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .token_kind_i    (out_o.token_kind),
  .length_i        (out_o.length),
  .integer_value_i (out_o.integer_value),
  .bad_char_i      (out_o.bad_char),
  .last_of_item_i  (out_o.last_of_item)
);

### tb/sv/tb_top.sv
// Self-checking testbench for the source text tokenizer: byte stimulus, token prediction, checks
`timescale 1ns / 100ps

import stt_pkg::*;

// Tracks the scanner position and open run, and holds the tokens still owed by the block
class token_tracker;
  logic [OFFSET_W-1:0] at_offset;
  logic [LINE_W-1:0]   at_line;
  logic [COLUMN_W-1:0] at_column;
  run_kind_e           run;
  logic [LINE_W-1:0]   run_line;
  logic [COLUMN_W-1:0] run_column;
  logic [OFFSET_W-1:0] run_offset;
  logic [LENGTH_W-1:0] run_len;
  bit                  run_dot;
  logic [VALUE_W-1:0]  run_val;
  logic [2:0]          kw_state;
  bit                  halted;
  tok_t                pending_tokens[$];
  int unsigned         mismatches;

  function new();
    mismatches = 0;
    rewind();
  endfunction

  // Back to the state after reset; owed tokens stay queued
  function void rewind();
    at_offset  = '0;
    at_line    = '0;
    at_column  = '0;
    run        = RUN_NONE;
    run_line   = '0;
    run_column = '0;
    run_offset = '0;
    run_len    = '0;
    run_dot    = 1'b0;
    run_val    = '0;
    kw_state   = '0;
    halted     = 1'b0;
  endfunction

  function bit is_letter(logic [7:0] c);
    // a..z, A..Z
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function bit is_digit(logic [7:0] c);
    return c >= CH_ZERO && c <= 8'h39;
  endfunction

  function void step();
    at_offset++;
    at_column++;
  endfunction

  function void emit(tok_kind_e k, logic [LINE_W-1:0] ln, logic [COLUMN_W-1:0] col,
                     logic [OFFSET_W-1:0] off, logic [LENGTH_W-1:0] len,
                     logic [VALUE_W-1:0] val, logic [7:0] bad);
    tok_t t;
    t.kind   = k;
    t.line   = ln;
    t.column = col;
    t.offset = off;
    t.length = len;
    t.value  = val;
    t.bad    = bad;
    t.last   = 1'b0;
    pending_tokens.push_back(t);
  endfunction

  // Emit the open identifier or number, if any
  function void close_run();
    tok_kind_e          k;
    logic [VALUE_W-1:0] val;
    if (run == RUN_NONE) return;
    val = '0;
    if (run == RUN_IDENT) begin
      if (kw_state == KW_DONE) k = TK_KEYWORD;
      else k = TK_IDENT;
    end else if (run_dot) begin
      k = TK_FLOAT;
    end else begin
      k   = TK_INTEGER;
      val = run_val;
    end
    emit(k, run_line, run_column, run_offset, run_len, val, 8'h00);
    run = RUN_NONE;
  endfunction

  // One accepted input word
  function void take_byte(logic [7:0] ch, logic eot);
    int unsigned        n_old;
    tok_kind_e          k;
    logic [VALUE_W-1:0] d;
    n_old = pending_tokens.size();
    if (eot) begin
      if (!halted) close_run();
      rewind();
    end else if (!halted) begin
      if ((run == RUN_IDENT && (is_letter(ch) || is_digit(ch) || ch == CH_UNDER)) ||
          (run == RUN_NUMBER && (is_digit(ch) || ch == CH_DOT))) begin
        // byte continues the open run
        if (run_len != '1) run_len++;
        if (run == RUN_IDENT) begin
          if (kw_state < KW_DONE && ch == KW_TEXT[kw_state]) kw_state++;
          else kw_state = KW_MISMATCH;
        end else if (ch == CH_DOT) begin
          run_dot = 1'b1;
        end else begin
          d = {56'd0, ch - CH_ZERO};
          if (run_val > ('1 - d) / 64'd10) run_val = '1;
          else run_val = run_val * 64'd10 + d;
        end
        step();
      end else begin
        close_run();
        case (ch)
          CH_SPACE, CH_TAB, CH_CR: step();
          CH_NL: begin
            step();
            at_line++;
            at_column = '0;
          end
          CH_EQ, CH_SEMI, CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH: begin
            case (ch)
              CH_EQ:    k = TK_EQUALS;
              CH_SEMI:  k = TK_SEMICOLON;
              CH_PLUS:  k = TK_PLUS;
              CH_MINUS: k = TK_MINUS;
              CH_STAR:  k = TK_ASTERISK;
              default:  k = TK_SLASH;
            endcase
            emit(k, at_line, at_column, at_offset, 1, '0, 8'h00);
            step();
          end
          default: begin
            if (is_letter(ch) || is_digit(ch)) begin
              // open a new run at this byte
              if (is_letter(ch)) begin
                run      = RUN_IDENT;
                run_val  = '0;
                kw_state = (ch == KW_TEXT[0]) ? 3'd1 : KW_MISMATCH;
              end else begin
                run      = RUN_NUMBER;
                run_val  = {56'd0, ch - CH_ZERO};
                kw_state = KW_MISMATCH;
              end
              run_line   = at_line;
              run_column = at_column;
              run_offset = at_offset;
              run_len    = 1;
              run_dot    = 1'b0;
              step();
            end else begin
              emit(TK_ERROR, at_line, at_column, at_offset, 1, '0, ch);
              halted = 1'b1;
            end
          end
        endcase
      end
    end
    if (pending_tokens.size() > n_old)
      pending_tokens[pending_tokens.size() - 1].last = 1'b1;
  endfunction

  task flag_mismatch(string msg);
    mismatches++;
    if (mismatches <= 100) $display("[%0t] MISMATCH %s", $time, msg);
  endtask

  task same(string field, logic [63:0] got, logic [63:0] want, logic [31:0] off);
    if (got !== want)
      flag_mismatch($sformatf("%s: got %0h, expected %0h (token at offset %0d)",
                              field, got, want, off));
  endtask

  // One accepted output word against the oldest owed token
  task match_token(tok_t got);
    tok_t want;
    if (pending_tokens.size() == 0) begin
      flag_mismatch($sformatf("token kind %0d at offset %0d with none expected",
                              got.kind, got.offset));
      return;
    end
    want = pending_tokens.pop_front();
    same("token_kind", got.kind, want.kind, want.offset);
    same("line", got.line, want.line, want.offset);
    same("column", got.column, want.column, want.offset);
    same("offset", got.offset, want.offset, want.offset);
    same("length", got.length, want.length, want.offset);
    same("integer_value", got.value, want.value, want.offset);
    same("bad_char", got.bad, want.bad, want.offset);
    same("last_of_item", got.last, want.last, want.offset);
  endtask
endclass

module tb_top;
  localparam int unsigned CLK_PERIOD  = 10;
  localparam int unsigned CYCLE_LIMIT = 200_000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned RAND_ITEMS  = 1000;

  logic clk_i = 1'b0;
  logic rst_ni;

  stt_in_if  in_if ();
  stt_out_if out_if ();

  source_text_tokenizer DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  token_tracker board;
  bit           calm;
  bit           sink_hold;
  int unsigned  live_items;
  int unsigned  cycle_cnt = 0;
  event         start_hold;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Run limit
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Long receiver hold-off, counted here
  initial begin
    sink_hold = 1'b0;
    forever begin
      @(start_hold);
      sink_hold = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk_i);
      sink_hold = 1'b0;
    end
  end

  // Token receiver: check accepted words, then pick next ready
  initial begin
    tok_t got;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
        got.kind   = tok_kind_e'(out_if.token_kind);
        got.line   = out_if.line;
        got.column = out_if.column;
        got.offset = out_if.offset;
        got.length = out_if.length;
        got.value  = out_if.integer_value;
        got.bad    = out_if.bad_char;
        got.last   = out_if.last_of_item;
        board.match_token(got);
      end
      if (rst_ni !== 1'b1 || sink_hold) out_if.ready <= 1'b0;
      else if (calm) out_if.ready <= 1'b1;
      else out_if.ready <= ($urandom_range(99) >= 28);
    end
  end

  // Offer one word, idling at random first; valid stays high after acceptance
  task automatic put_word(input logic [7:0] ch, input logic eot);
    while (!calm && $urandom_range(99) < 28) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.character   <= ch;
    in_if.end_of_text <= eot;
    @(posedge clk_i);
    while (in_if.ready !== 1'b1) @(posedge clk_i);
    if (!board.halted || eot) live_items++;
    board.take_byte(ch, eot);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) put_word(s[i], 1'b0);
  endtask

  task automatic send_eot();
    put_word(8'($urandom_range(255)), 1'b1);
  endtask

  // Stop offering and wait until every owed token has come back
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (board.pending_tokens.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [7:0] rand_letter();
    logic [7:0] r;
    r = 8'($urandom_range(25));
    return $urandom_range(1) ? 8'h61 + r : 8'h41 + r;
  endfunction

  // One random lexical piece; mostly well-formed text
  task automatic send_piece();
    string      kw_like[6] = '{"func", "fun", "funcs", "f", "func_", "Func"};
    logic [7:0] ops[6]     = '{CH_EQ, CH_SEMI, CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH};
    logic [7:0] blanks[5]  = '{CH_SPACE, CH_TAB, CH_CR, CH_NL, CH_SPACE};
    int         sel;
    int         n;
    sel = $urandom_range(999);
    if (sel < 300) begin
      // identifier, sometimes close to the keyword
      if ($urandom_range(3) == 0) begin
        send_text(kw_like[$urandom_range(5)]);
      end else begin
        put_word(rand_letter(), 1'b0);
        n = $urandom_range(7);
        repeat (n) begin
          case ($urandom_range(2))
            0:       put_word(rand_letter(), 1'b0);
            1:       put_word(CH_ZERO + 8'($urandom_range(9)), 1'b0);
            default: put_word(CH_UNDER, 1'b0);
          endcase
        end
      end
    end else if (sel < 500) begin
      // number; a few long enough to saturate, some with dots
      n = ($urandom_range(19) == 0) ? $urandom_range(25, 20) : $urandom_range(6, 1);
      put_word(CH_ZERO + 8'($urandom_range(9)), 1'b0);
      repeat (n - 1) begin
        if ($urandom_range(19) == 0) put_word(CH_DOT, 1'b0);
        else put_word(CH_ZERO + 8'($urandom_range(9)), 1'b0);
      end
    end else if (sel < 700) begin
      put_word(ops[$urandom_range(5)], 1'b0);
    end else if (sel < 935) begin
      put_word(blanks[$urandom_range(4)], 1'b0);
    end else if (sel < 985) begin
      send_eot();
    end else begin
      put_word(8'($urandom_range(255)), 1'b0);
    end
  endtask

  // Stimulus
  initial begin
    logic [7:0] bad_bytes[7] = '{8'h00, 8'h0B, 8'h0C, 8'h7F, 8'h80, 8'hFF, 8'h40};
    int unsigned goal;
    int unsigned piece;
    board      = new();
    calm       = 1'b0;
    live_items = 0;
    rst_ni            <= 1'b0;
    in_if.valid       <= 1'b0;
    in_if.character   <= 8'h00;
    in_if.end_of_text <= 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: keyword, every operator, blanks, flush at end of text, error after a run
    send_text("func=Ab_9;");
    send_text(" \t\r\n+-*/");
    send_text("42");
    send_eot();
    send_eot();
    send_text("x");
    put_word(8'h00, 1'b0);
    send_text("7");
    send_eot();
    wait_drained();

    // Value saturation, floats with many dots, each kind of bad byte
    send_text("18446744073709551615 18446744073709551616 ");
    send_text("99999999999999999999999;1.2.3.");
    send_eot();
    foreach (bad_bytes[i]) begin
      send_text("ab");
      put_word(bad_bytes[i], 1'b0);
      send_text("z=");
      send_eot();
    end
    wait_drained();

    // Random text
    goal  = live_items + RAND_ITEMS;
    piece = 0;
    while (live_items < goal) begin
      if (piece == 20) -> start_hold;
      calm = (piece >= 150 && piece < 230);
      if (piece == 300) wait_drained();
      send_piece();
      piece++;
    end
    calm = 1'b0;
    send_eot();

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (board.mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

### files.f
+incdir+design
design/stt_pkg.sv
design/stt_if.sv
design/stt_fifo.sv
design/stt_core.sv
design/source_text_tokenizer.sv
design/stt_checker.sv
tb/sv/tb_top.sv
